FILE: sv/fhp_pkg.sv
`default_nettype none

package fhp_pkg;

    localparam int BYTE_W   = 8;
    localparam int BLOCK_W  = 17;
    localparam int RATE_W   = 20;
    localparam int NCH_W    = 4;
    localparam int MODE_W   = 2;
    localparam int BITS_W   = 6;
    localparam int STATUS_W = 3;
    localparam int RESULT_W = 61;
    localparam int TDATA_W  = 64;

    localparam logic [13:0] FRAME_SYNC = 14'h3FFE;

    // block-size codes
    localparam logic [3:0] BC_RESERVED = 4'd0;
    localparam logic [3:0] BC_192      = 4'd1;
    localparam logic [3:0] BC_EXT8     = 4'd6;
    localparam logic [3:0] BC_EXT16    = 4'd7;

    localparam logic [BLOCK_W-1:0] BLK_192 = 17'd192;
    localparam logic [BLOCK_W-1:0] BLK_576 = 17'd576;
    localparam logic [BLOCK_W-1:0] BLK_256 = 17'd256;

    // sample-rate codes
    localparam logic [3:0] RC_STREAM   = 4'd0;
    localparam logic [3:0] RC_KHZ      = 4'd12;
    localparam logic [3:0] RC_HZ       = 4'd13;
    localparam logic [3:0] RC_TENS_HZ  = 4'd14;
    localparam logic [3:0] RC_RESERVED = 4'd15;

    localparam logic [RATE_W-1:0] KHZ_SCALE  = 20'd1000;
    localparam logic [RATE_W-1:0] TENS_SCALE = 20'd10;

    // sample-size codes
    localparam logic [2:0] SC_STREAM   = 3'd0;
    localparam logic [2:0] SC_RESERVED = 3'd3;

    // channel assignment
    localparam logic [3:0] CC_LAST_INDEP = 4'd7;
    localparam logic [3:0] CC_LAST_STEREO = 4'd10;

    localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_SYNC      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RSVD_CHANNELS = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RSVD_SIZE     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RSVD_RATE     = 3'd4;

    localparam logic CFG_STREAM_RATE = 1'b0;
    localparam logic CFG_STREAM_BITS = 1'b1;

    typedef struct packed {
        logic [15:0]        first_two;
        logic [7:0]         codes;
        logic [7:0]         chan_size;
        logic [BLOCK_W-1:0] ext_block;
        logic [RATE_W-1:0]  ext_rate;
    } fhp_hdr_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   header_crc;
        logic                variable_blocking;
        logic [BITS_W-1:0]   sample_bits;
        logic [MODE_W-1:0]   channel_mode;
        logic [NCH_W-1:0]    chan_count;
        logic [RATE_W-1:0]   rate_hz;
        logic [BLOCK_W-1:0]  blk_len;
    } fhp_result_t;

    function automatic logic [RATE_W-1:0] fixed_rate(input logic [3:0] code);
        logic [RATE_W-1:0] r;
        case (code)
            4'd1:    r = 20'd88200;
            4'd2:    r = 20'd176400;
            4'd3:    r = 20'd192000;
            4'd4:    r = 20'd8000;
            4'd5:    r = 20'd16000;
            4'd6:    r = 20'd22050;
            4'd7:    r = 20'd24000;
            4'd8:    r = 20'd32000;
            4'd9:    r = 20'd44100;
            4'd10:   r = 20'd48000;
            4'd11:   r = 20'd96000;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [BITS_W-1:0] size_bits(input logic [2:0] code);
        logic [BITS_W-1:0] r;
        case (code)
            3'd1:    r = 6'd8;
            3'd2:    r = 6'd12;
            3'd4:    r = 6'd16;
            3'd5:    r = 6'd20;
            3'd6:    r = 6'd24;
            3'd7:    r = 6'd32;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/fhp_decode.sv
`default_nettype none

module fhp_decode
    import fhp_pkg::*;
(
    input  fhp_hdr_t            hdr,
    input  logic [RATE_W-1:0]   stream_rate,
    input  logic [BITS_W-1:0]   stream_bits,
    input  logic [BYTE_W-1:0]   crc_byte,
    output fhp_result_t         result
);

    logic [3:0] bc;
    logic [3:0] rc;
    logic [3:0] cc;
    logic [2:0] sc;
    logic [1:0] bc_less2;
    logic       sync_ok;

    assign bc       = hdr.codes[7:4];
    assign rc       = hdr.codes[3:0];
    assign cc       = hdr.chan_size[7:4];
    assign sc       = hdr.chan_size[3:1];
    assign bc_less2 = bc[1:0] - 2'd2;
    assign sync_ok  = (hdr.first_two[15:2] == FRAME_SYNC);

    always_comb begin
        result = '0;

        case (bc) inside
            BC_RESERVED:        result.blk_len = '0;
            BC_192:             result.blk_len = BLK_192;
            [4'd2:4'd5]:        result.blk_len = BLK_576 << bc_less2;
            BC_EXT8, BC_EXT16:  result.blk_len = hdr.ext_block;
            default:            result.blk_len = BLK_256 << bc[2:0];
        endcase

        case (rc) inside
            RC_STREAM:                  result.rate_hz = stream_rate;
            RC_KHZ, RC_HZ, RC_TENS_HZ:  result.rate_hz = hdr.ext_rate;
            RC_RESERVED:                result.rate_hz = '0;
            default:                    result.rate_hz = fixed_rate(rc);
        endcase

        if (cc <= CC_LAST_INDEP) begin
            result.chan_count   = cc + 4'd1;
            result.channel_mode = '0;
        end else if (cc <= CC_LAST_STEREO) begin
            result.chan_count   = 4'd2;
            result.channel_mode = MODE_W'(cc - CC_LAST_INDEP);
        end else begin
            result.chan_count   = '0;
            result.channel_mode = '0;
        end

        result.sample_bits       = (sc == SC_STREAM) ? stream_bits : size_bits(sc);
        result.variable_blocking = hdr.first_two[0];
        result.header_crc        = crc_byte;

        if (!sync_ok) begin
            result.status = ST_BAD_SYNC;
        end else if (cc > CC_LAST_STEREO) begin
            result.status = ST_RSVD_CHANNELS;
        end else if (bc == BC_RESERVED || sc == SC_RESERVED) begin
            result.status = ST_RSVD_SIZE;
        end else if (rc == RC_RESERVED) begin
            result.status = ST_RSVD_RATE;
        end else begin
            result.status = ST_OK;
        end
    end

endmodule

`default_nettype wire

FILE: sv/flac_frame_header_parser.sv
// One header byte per transfer, one byte accepted every cycle while s_tready is high.
// The decoded result appears in the cycle after the CRC byte transfer, held in an
// output register; bytes keep flowing while it waits, and only a byte that
// arrives in the CRC phase stalls until the register is free.
// Synchronous active-low reset returns the parser to idle (waiting for a
// frame start), clears the output valid, and sets stream bits to 16.
`default_nettype none

module flac_frame_header_parser
    import fhp_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                s_tvalid,
    output      logic                s_tready,
    input  wire logic [BYTE_W-1:0]   s_tdata,   // [7:0] header_byte
    input  wire logic                s_tuser,   // [0] frame_start

    output      logic                m_tvalid,
    input  wire logic                m_tready,
    // [16:0] samples per channel, [36:17] rate in Hz, [40:37] channel count,
    // [42:41] channel_mode, [48:43] sample_bits, [49] variable_blocking,
    // [57:50] header_crc, [60:58] status, [63:61] zero
    output      logic [TDATA_W-1:0]  m_tdata,

    input  wire logic                cfg_valid,
    output      logic                cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic [RATE_W-1:0]   cfg_data
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_BYTE1,
        PH_CODES,
        PH_CHAN_SIZE,
        PH_NUM_FIRST,
        PH_NUM_REST,
        PH_EXT_BLOCK,
        PH_EXT_RATE,
        PH_CRC
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [15:0]         first_two_reg, first_two_next;
    logic [7:0]          codes_reg, codes_next;
    logic [7:0]          chan_size_reg, chan_size_next;
    logic [2:0]          num_left_reg, num_left_next;
    logic [15:0]         ext_val_reg, ext_val_next;
    logic [1:0]          ext_left_reg, ext_left_next;
    logic [BLOCK_W-1:0]  ext_block_reg, ext_block_next;
    logic [RATE_W-1:0]   ext_rate_reg, ext_rate_next;
    logic                m_valid_reg, m_valid_next;
    fhp_result_t         result_reg;
    logic [RATE_W-1:0]   stream_rate_reg;
    logic [BITS_W-1:0]   stream_bits_reg;

    logic                s_fire;
    logic                crc_fire;
    logic [7:0]          b;
    logic [3:0]          lead_ones;
    logic                run;
    logic [2:0]          num_total;
    logic [2:0]          num_dec;
    logic [1:0]          ext_dec;
    logic [15:0]         ext_shift;
    phase_t              rate_phase;
    logic [1:0]          rate_left;
    phase_t              after_phase;
    logic [1:0]          after_left;
    fhp_hdr_t            hdr;
    fhp_result_t         dec_result;

    assign b         = s_tdata;
    assign s_tready  = (phase_reg != PH_CRC) || !m_valid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;
    assign crc_fire  = s_fire && !s_tuser && (phase_reg == PH_CRC);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {(TDATA_W - RESULT_W)'(0), result_reg};

    assign num_dec   = num_left_reg - 3'd1;
    assign ext_dec   = ext_left_reg - 2'd1;
    assign ext_shift = {ext_val_reg[7:0], b};

    assign hdr.first_two = first_two_reg;
    assign hdr.codes     = codes_reg;
    assign hdr.chan_size = chan_size_reg;
    assign hdr.ext_block = ext_block_reg;
    assign hdr.ext_rate  = ext_rate_reg;

    fhp_decode u_decode (
        .hdr         (hdr),
        .stream_rate (stream_rate_reg),
        .stream_bits (stream_bits_reg),
        .crc_byte    (b),
        .result      (dec_result)
    );

    // leading ones of the first coded-number byte
    always_comb begin
        lead_ones = '0;
        run       = 1'b1;
        for (int i = 7; i >= 0; i--) begin
            if (run && b[i]) begin
                lead_ones = lead_ones + 4'd1;
            end else begin
                run = 1'b0;
            end
        end
        if (lead_ones < 4'd2) begin
            num_total = 3'd1;
        end else if (lead_ones > 4'd7) begin
            num_total = 3'd7;
        end else begin
            num_total = lead_ones[2:0];
        end
    end

    always_comb begin
        case (codes_reg[3:0])
            RC_KHZ: begin
                rate_phase = PH_EXT_RATE;
                rate_left  = 2'd1;
            end
            RC_HZ, RC_TENS_HZ: begin
                rate_phase = PH_EXT_RATE;
                rate_left  = 2'd2;
            end
            default: begin
                rate_phase = PH_CRC;
                rate_left  = 2'd0;
            end
        endcase
        case (codes_reg[7:4])
            BC_EXT8: begin
                after_phase = PH_EXT_BLOCK;
                after_left  = 2'd1;
            end
            BC_EXT16: begin
                after_phase = PH_EXT_BLOCK;
                after_left  = 2'd2;
            end
            default: begin
                after_phase = rate_phase;
                after_left  = rate_left;
            end
        endcase
    end

    always_comb begin
        phase_next     = phase_reg;
        first_two_next = first_two_reg;
        codes_next     = codes_reg;
        chan_size_next = chan_size_reg;
        num_left_next  = num_left_reg;
        ext_val_next   = ext_val_reg;
        ext_left_next  = ext_left_reg;
        ext_block_next = ext_block_reg;
        ext_rate_next  = ext_rate_reg;
        m_valid_next   = m_valid_reg && !m_tready;

        if (s_fire) begin
            if (s_tuser) begin
                first_two_next = {b, 8'h00};
                phase_next     = PH_BYTE1;
            end else begin
                case (phase_reg)
                    PH_BYTE1: begin
                        first_two_next = first_two_reg | {8'h00, b};
                        phase_next     = PH_CODES;
                    end
                    PH_CODES: begin
                        codes_next = b;
                        phase_next = PH_CHAN_SIZE;
                    end
                    PH_CHAN_SIZE: begin
                        chan_size_next = b;
                        phase_next     = PH_NUM_FIRST;
                    end
                    PH_NUM_FIRST: begin
                        num_left_next = num_total - 3'd1;
                        if (num_total != 3'd1) begin
                            phase_next = PH_NUM_REST;
                        end else begin
                            ext_val_next  = '0;
                            ext_left_next = after_left;
                            phase_next    = after_phase;
                        end
                    end
                    PH_NUM_REST: begin
                        num_left_next = num_dec;
                        if (num_dec == 3'd0) begin
                            ext_val_next  = '0;
                            ext_left_next = after_left;
                            phase_next    = after_phase;
                        end
                    end
                    PH_EXT_BLOCK: begin
                        ext_val_next  = ext_shift;
                        ext_left_next = ext_dec;
                        if (ext_dec == 2'd0) begin
                            ext_block_next = {1'b0, ext_shift} + BLOCK_W'(1);
                            ext_val_next   = '0;
                            ext_left_next  = rate_left;
                            phase_next     = rate_phase;
                        end
                    end
                    PH_EXT_RATE: begin
                        ext_val_next  = ext_shift;
                        ext_left_next = ext_dec;
                        if (ext_dec == 2'd0) begin
                            case (codes_reg[3:0])
                                RC_KHZ:     ext_rate_next = RATE_W'(ext_shift) * KHZ_SCALE;
                                RC_TENS_HZ: ext_rate_next = RATE_W'(ext_shift) * TENS_SCALE;
                                default:    ext_rate_next = RATE_W'(ext_shift);
                            endcase
                            phase_next = PH_CRC;
                        end
                    end
                    PH_CRC: begin
                        m_valid_next = 1'b1;
                        phase_next   = PH_IDLE;
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            first_two_reg   <= '0;
            codes_reg       <= '0;
            chan_size_reg   <= '0;
            num_left_reg    <= '0;
            ext_val_reg     <= '0;
            ext_left_reg    <= '0;
            ext_block_reg   <= '0;
            ext_rate_reg    <= '0;
            m_valid_reg     <= 1'b0;
            stream_rate_reg <= '0;
            stream_bits_reg <= 6'd16;
        end else begin
            phase_reg     <= phase_next;
            first_two_reg <= first_two_next;
            codes_reg     <= codes_next;
            chan_size_reg <= chan_size_next;
            num_left_reg  <= num_left_next;
            ext_val_reg   <= ext_val_next;
            ext_left_reg  <= ext_left_next;
            ext_block_reg <= ext_block_next;
            ext_rate_reg  <= ext_rate_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_STREAM_RATE: stream_rate_reg <= cfg_data;
                    CFG_STREAM_BITS: stream_bits_reg <= cfg_data[BITS_W-1:0];
                    default:         stream_rate_reg <= stream_rate_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (crc_fire) begin
            result_reg <= dec_result;
        end
    end

    a_crc_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        crc_fire |=> m_tvalid && phase_reg == PH_IDLE)
        else $error("CRC byte transfer did not produce a result");

    a_start_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> phase_reg == PH_BYTE1)
        else $error("frame start did not restart the parser");

    a_stall_only_on_crc: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> phase_reg == PH_CRC && m_valid_reg && !m_tready)
        else $error("input stalled outside a full-output CRC wait");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> result_reg.status == ST_OK || result_reg.status == ST_BAD_SYNC
            || result_reg.status == ST_RSVD_CHANNELS || result_reg.status == ST_RSVD_SIZE
            || result_reg.status == ST_RSVD_RATE)
        else $error("result status out of range");

endmodule

`default_nettype wire

FILE: sim/flac_frame_header_parser_checker.sv
`timescale 1ns / 1ps

module flac_frame_header_parser_checker
    import fhp_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                s_tvalid,
    input  wire logic                s_tready,
    input  wire logic [BYTE_W-1:0]   s_tdata,
    input  wire logic                s_tuser,

    input  wire logic                m_tvalid,
    input  wire logic                m_tready,
    input  wire logic [TDATA_W-1:0]  m_tdata,

    input  wire logic                cfg_valid,
    input  wire logic                cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic [RATE_W-1:0]   cfg_data,

    output int                       fail_total,
    output int                       pending,
    output int                       decoded_total
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_SYNC_LO,
        PH_CODES,
        PH_CHAN_SIZE,
        PH_NUM_HEAD,
        PH_NUM_TAIL,
        PH_EXT_BLOCK,
        PH_EXT_RATE,
        PH_CRC
    } parse_phase_t;

    localparam logic [3:0] BC_576      = 4'd2;
    localparam logic [3:0] BC_576_LAST = 4'd5;
    localparam logic [3:0] BC_256      = 4'd8;

    parse_phase_t        phase;
    logic [15:0]         sync_word;
    logic [7:0]          codes;
    logic [7:0]          chan_size;
    logic [2:0]          num_left;
    logic [2:0]          ext_left;
    logic [15:0]         ext_acc;
    logic [BLOCK_W-1:0]  ext_blk;
    logic [RATE_W-1:0]   ext_hz;

    logic [RATE_W-1:0]   stream_rate;
    logic [BITS_W-1:0]   stream_bits;

    logic [RATE_W-1:0]   std_rate [16];
    logic [BITS_W-1:0]   std_bits [8];

    fhp_result_t         decoded_q [$];
    fhp_result_t         got;
    fhp_result_t         want;

    int                  fails;
    int                  decoded;

    initial begin
        std_rate = '{20'd0, 20'd88200, 20'd176400, 20'd192000, 20'd8000, 20'd16000,
                     20'd22050, 20'd24000, 20'd32000, 20'd44100, 20'd48000, 20'd96000,
                     20'd0, 20'd0, 20'd0, 20'd0};
        std_bits = '{6'd0, 6'd8, 6'd12, 6'd0, 6'd16, 6'd20, 6'd24, 6'd32};
    end

    task automatic report(input string what, input longint unsigned got_v,
                          input longint unsigned want_v);
        $display("%t MISMATCH %s: got %0d, expected %0d", $realtime, what, got_v, want_v);
        fails++;
    endtask

    function automatic int leading_ones(input logic [7:0] b);
        int n;
        n = 0;
        while (n < 8 && b[7-n])
            n++;
        return n;
    endfunction

    function automatic void enter_rate_field();
        ext_acc = '0;
        if (codes[3:0] == RC_KHZ) begin
            ext_left = 3'd1;
            phase = PH_EXT_RATE;
        end else if (codes[3:0] == RC_HZ || codes[3:0] == RC_TENS_HZ) begin
            ext_left = 3'd2;
            phase = PH_EXT_RATE;
        end else begin
            phase = PH_CRC;
        end
    endfunction

    function automatic void number_done();
        ext_acc = '0;
        if (codes[7:4] == BC_EXT8) begin
            ext_left = 3'd1;
            phase = PH_EXT_BLOCK;
        end else if (codes[7:4] == BC_EXT16) begin
            ext_left = 3'd2;
            phase = PH_EXT_BLOCK;
        end else begin
            enter_rate_field();
        end
    endfunction

    function automatic fhp_result_t decode_header(input logic [7:0] crc);
        fhp_result_t r;
        logic [3:0]  bc;
        logic [3:0]  rc;
        logic [3:0]  cc;
        logic [2:0]  sc;
        bc = codes[7:4];
        rc = codes[3:0];
        cc = chan_size[7:4];
        sc = chan_size[3:1];
        r = '0;

        if (bc == BC_RESERVED)
            r.blk_len = '0;
        else if (bc == BC_192)
            r.blk_len = BLK_192;
        else if (bc <= BC_576_LAST)
            r.blk_len = BLK_576 << (bc - BC_576);
        else if (bc <= BC_EXT16)
            r.blk_len = ext_blk;
        else
            r.blk_len = BLK_256 << (bc - BC_256);

        if (rc == RC_STREAM)
            r.rate_hz = stream_rate;
        else if (rc < RC_KHZ)
            r.rate_hz = std_rate[rc];
        else if (rc != RC_RESERVED)
            r.rate_hz = ext_hz;

        if (cc <= CC_LAST_INDEP) begin
            r.chan_count = cc + 4'd1;
        end else if (cc <= CC_LAST_STEREO) begin
            r.chan_count = 4'd2;
            r.channel_mode = 2'(cc - CC_LAST_INDEP);
        end

        r.sample_bits = (sc == SC_STREAM) ? stream_bits : std_bits[sc];
        r.variable_blocking = sync_word[0];
        r.header_crc = crc;

        if (sync_word[15:2] != FRAME_SYNC)
            r.status = ST_BAD_SYNC;
        else if (cc > CC_LAST_STEREO)
            r.status = ST_RSVD_CHANNELS;
        else if (bc == BC_RESERVED || sc == SC_RESERVED)
            r.status = ST_RSVD_SIZE;
        else if (rc == RC_RESERVED)
            r.status = ST_RSVD_RATE;
        else
            r.status = ST_OK;
        return r;
    endfunction

    function automatic void take_byte(input logic [7:0] b, input logic start);
        int n;
        if (start) begin
            sync_word = {b, 8'h00};
            phase = PH_SYNC_LO;
            return;
        end
        case (phase)
            PH_SYNC_LO: begin
                sync_word[7:0] = b;
                phase = PH_CODES;
            end
            PH_CODES: begin
                codes = b;
                phase = PH_CHAN_SIZE;
            end
            PH_CHAN_SIZE: begin
                chan_size = b;
                phase = PH_NUM_HEAD;
            end
            PH_NUM_HEAD: begin
                n = leading_ones(b);
                // one leading one is invalid and counts as a single byte
                n = (n < 2) ? 1 : ((n > 7) ? 7 : n);
                num_left = 3'(n - 1);
                if (num_left != 0)
                    phase = PH_NUM_TAIL;
                else
                    number_done();
            end
            PH_NUM_TAIL: begin
                num_left = num_left - 3'd1;
                if (num_left == 0)
                    number_done();
            end
            PH_EXT_BLOCK: begin
                ext_acc = {ext_acc[7:0], b};
                ext_left = ext_left - 3'd1;
                if (ext_left == 0) begin
                    ext_blk = {1'b0, ext_acc} + 17'd1;
                    enter_rate_field();
                end
            end
            PH_EXT_RATE: begin
                ext_acc = {ext_acc[7:0], b};
                ext_left = ext_left - 3'd1;
                if (ext_left == 0) begin
                    if (codes[3:0] == RC_KHZ)
                        ext_hz = RATE_W'(ext_acc) * KHZ_SCALE;
                    else if (codes[3:0] == RC_TENS_HZ)
                        ext_hz = RATE_W'(ext_acc) * TENS_SCALE;
                    else
                        ext_hz = RATE_W'(ext_acc);
                    phase = PH_CRC;
                end
            end
            PH_CRC: begin
                decoded_q.push_back(decode_header(b));
                phase = PH_IDLE;
            end
            default: ;
        endcase
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            phase = PH_IDLE;
            sync_word = '0;
            codes = '0;
            chan_size = '0;
            num_left = '0;
            ext_left = '0;
            ext_acc = '0;
            ext_blk = '0;
            ext_hz = '0;
            stream_rate = '0;
            stream_bits = 6'd16;
            decoded_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_STREAM_RATE: stream_rate = cfg_data;
                    CFG_STREAM_BITS: stream_bits = cfg_data[BITS_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                take_byte(s_tdata, s_tuser);
            if (m_tvalid && m_tready) begin
                if (decoded_q.size() == 0) begin
                    report("unexpected transfer, tdata", m_tdata, 0);
                end else begin
                    want = decoded_q.pop_front();
                    got = fhp_result_t'(m_tdata[RESULT_W-1:0]);
                    decoded++;
                    if (got.blk_len != want.blk_len)
                        report("blk_len", got.blk_len, want.blk_len);
                    if (got.rate_hz != want.rate_hz)
                        report("rate_hz", got.rate_hz, want.rate_hz);
                    if (got.chan_count != want.chan_count)
                        report("chan_count", got.chan_count, want.chan_count);
                    if (got.channel_mode != want.channel_mode)
                        report("channel_mode", got.channel_mode, want.channel_mode);
                    if (got.sample_bits != want.sample_bits)
                        report("sample_bits", got.sample_bits, want.sample_bits);
                    if (got.variable_blocking != want.variable_blocking)
                        report("variable_blocking", got.variable_blocking,
                               want.variable_blocking);
                    if (got.header_crc != want.header_crc)
                        report("header_crc", got.header_crc, want.header_crc);
                    if (got.status != want.status)
                        report("status", got.status, want.status);
                    if (m_tdata[TDATA_W-1:RESULT_W] != '0)
                        report("tdata padding", m_tdata[TDATA_W-1:RESULT_W], 0);
                end
            end
        end
        fail_total <= fails;
        pending <= decoded_q.size();
        decoded_total <= decoded;
    end

endmodule

FILE: sim/flac_frame_header_parser_tb.sv
`timescale 1ns / 1ps

module flac_frame_header_parser_tb;
    import fhp_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              start;
    } hdr_byte_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;

    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [BYTE_W-1:0]   s_tdata = '0;
    logic                s_tuser = 1'b0;

    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;

    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_index = CFG_STREAM_RATE;
    logic [RATE_W-1:0]   cfg_data = '0;

    int                  fail_total;
    int                  pending;
    int                  decoded_total;

    hdr_byte_t           byte_q [$];
    int                  send_idle_pct = 0;
    int                  stall_pct = 0;
    int                  hold_left = 0;
    logic                hold_req = 1'b0;
    logic                hold_seen = 1'b0;
    int                  bytes_sent = 0;
    int                  settings_done = 0;

    always #5 aclk = ~aclk;

    flac_frame_header_parser u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    flac_frame_header_parser_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_total    (fail_total),
        .pending       (pending),
        .decoded_total (decoded_total)
    );

    // receiver: long hold-off when requested, random stalls otherwise
    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 400;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic void add_byte(input logic [7:0] b, input logic start);
        hdr_byte_t it;
        it.data = b;
        it.start = start;
        byte_q.push_back(it);
    endfunction

    // the low n bytes of v, most significant first, first one flagged as frame start
    function automatic void add_packed(input logic [127:0] v, input int n);
        for (int i = 0; i < n; i++)
            add_byte(v[8*(n-i)-1 -: 8], i == 0);
    endfunction

    function automatic int add_random_header(input bit broken);
        logic [7:0] hb [$];
        logic [3:0] bc;
        logic [3:0] rc;
        logic [7:0] lead_mask;
        int         lead;
        int         total;
        int         keep;
        bc = 4'($urandom);
        rc = 4'($urandom);
        if ($urandom_range(9) == 0) begin
            hb.push_back(8'($urandom));
            hb.push_back(8'($urandom));
        end else begin
            hb.push_back(8'hFF);
            hb.push_back({6'b111110, 2'($urandom)});
        end
        hb.push_back({bc, rc});
        hb.push_back(8'($urandom));
        lead = $urandom_range(8);
        lead_mask = 8'hFF >> lead;
        hb.push_back(~lead_mask | (8'($urandom) & (lead_mask >> 1)));
        total = (lead < 2) ? 1 : ((lead > 7) ? 7 : lead);
        repeat (total - 1) hb.push_back(8'($urandom));
        if (bc == BC_EXT8 || bc == BC_EXT16)
            hb.push_back(8'($urandom));
        if (bc == BC_EXT16)
            hb.push_back(8'($urandom));
        if (rc == RC_KHZ || rc == RC_HZ || rc == RC_TENS_HZ)
            hb.push_back(8'($urandom));
        if (rc == RC_HZ || rc == RC_TENS_HZ)
            hb.push_back(8'($urandom));
        hb.push_back(8'($urandom));
        keep = broken ? $urandom_range(hb.size() - 1, 1) : hb.size();
        for (int i = 0; i < keep; i++)
            add_byte(hb[i], i == 0);
        return keep;
    endfunction

    task automatic send_bytes();
        hdr_byte_t it;
        while (byte_q.size() > 0) begin
            if ($urandom_range(99) < send_idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end else begin
                it = byte_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= it.data;
                s_tuser <= it.start;
                do @(posedge aclk); while (!s_tready);
                bytes_sent++;
            end
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_config(input logic [RATE_W-1:0] rate, input logic [BITS_W-1:0] bits);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_STREAM_RATE;
        cfg_data <= rate;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_STREAM_BITS;
        cfg_data <= RATE_W'(bits);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        settings_done++;
    endtask

    task automatic run_random(input int idle_pct, input int stall, input int n_bytes);
        int made;
        int pick;
        made = 0;
        send_idle_pct = idle_pct;
        stall_pct = stall;
        while (made < n_bytes) begin
            pick = $urandom_range(99);
            if (pick < 85) begin
                made += add_random_header(1'b0);
            end else if (pick < 93) begin
                made += add_random_header(1'b1);
            end else begin
                repeat ($urandom_range(4, 1))
                    add_byte(8'($urandom), $urandom_range(3) == 0);
            end
        end
        send_bytes();
        wait_drained();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset config: stray byte, restart mid-header, extremes, all-reserved bad sync
        add_byte(8'h00, 1'b0);
        add_packed(128'hFFF8, 2);
        add_packed(128'hFFF97CAEC080FFFFFFFF, 10);
        add_packed(128'h00000FF6FF00000000000000, 12);
        add_packed(128'hFFF86DB38000000001, 9);
        send_bytes();
        wait_drained();

        // stream rate and stream bits used via code 0
        write_config(20'hFFFFF, 6'd32);
        add_packed(128'hFFF880000000, 6);
        add_packed(128'hFFFA1E010F00, 6);
        send_bytes();
        wait_drained();

        write_config(20'h00000, 6'd4);
        run_random(0, 0, 430);
        write_config(20'($urandom), 6'($urandom_range(32, 4)));
        run_random(63, 0, 430);
        write_config(20'hFFFFF, 6'd32);
        run_random(0, 63, 430);
        write_config(20'($urandom), 6'($urandom_range(32, 4)));
        run_random(19, 19, 430);

        // long output hold-off while the sender keeps pushing
        write_config(20'($urandom), 6'($urandom_range(32, 4)));
        hold_req <= ~hold_req;
        run_random(0, 0, 150);

        $display("Sent %0d header bytes under %0d stream settings and four idle/stall mixes,",
                 bytes_sent, settings_done);
        $display("plus a 400-cycle output hold; %0d decoded headers compared.", decoded_total);
        if (fail_total == 0 && pending == 0) begin
            $display("flac_frame_header_parser_tb passed");
        end else begin
            $display("flac_frame_header_parser_tb failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timeout with %0d results outstanding", pending);
        $display("flac_frame_header_parser_tb failed");
        $finish;
    end

endmodule

FILE: flac_frame_header_parser.f
sv/fhp_pkg.sv
sv/fhp_decode.sv
sv/flac_frame_header_parser.sv
sim/flac_frame_header_parser_checker.sv
sim/flac_frame_header_parser_tb.sv
